FILE: rtl/peer_link_manager_assert.svh
// Assertion helpers for the peer link manager.
`ifndef PEER_LINK_MANAGER_ASSERT_SVH
`define PEER_LINK_MANAGER_ASSERT_SVH

// same-cycle implication
`define PLM_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLM_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/plm_pkg.sv
`default_nettype none
package plm_pkg;

    localparam int KIND_W   = 3;
    localparam int PEER_W   = 3;
    localparam int ACT_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;
    localparam int MASK_W   = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 3'd0,
        KIND_RECONNECT  = 3'd1,
        KIND_CONN_ECHO  = 3'd2,
        KIND_LOGIN_ACK  = 3'd3,
        KIND_LOGIN_NACK = 3'd4,
        KIND_KEEPALIVE  = 3'd5,
        KIND_DISCONNECT = 3'd6
    } t_kind;

    typedef enum logic [ACT_W-1:0] {
        ACT_CONNECT    = 3'd0,
        ACT_LOGIN      = 3'd1,
        ACT_KEEPALIVE  = 3'd2,
        ACT_DISCONNECT = 3'd3,
        ACT_ADD        = 3'd4,
        ACT_REMOVE     = 3'd5,
        ACT_ALIVE      = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        LS_DISC  = 2'd0,
        LS_CONN  = 2'd1,
        LS_LOGIN = 2'd2,
        LS_UP    = 2'd3
    } t_link;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MASK  = 3'd0,
        REG_RECONNECT    = 3'd1,
        REG_HS_TIMEOUT   = 3'd2,
        REG_KA_PERIOD    = 3'd3,
        REG_KA_TIMEOUT   = 3'd4
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CALC = 5'b00100,
        S_SEC  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [CFG_W-1:0] RST_RECONNECT  = 16'd5;
    localparam logic [CFG_W-1:0] RST_HS_TIMEOUT = 16'd5;
    localparam logic [CFG_W-1:0] RST_KA_PERIOD  = 16'd1;
    localparam logic [CFG_W-1:0] RST_KA_TIMEOUT = 16'd30;

endpackage
`default_nettype wire

FILE: rtl/plm_ram.sv
`default_nettype none
module plm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/peer_link_manager.sv
// A packet item's result strobes in the first cycle with busy low.
// A tick or reconnect walks the entries: per enabled entry one read-modify-write of the link memory
// (RD then CALC, plus SEC for an entry with two results); a disabled entry passes through RD only.
// Results are held one deep so the final one can carry last; the receiver cannot stall.
// Reset (synchronous, active low): registers return to 0, 5, 5, 1, 30, no entry enabled.
// Newly enabled entries read as cleared through per-entry fresh bits, no clearing pass.
`default_nettype none
module peer_link_manager #(
    parameter int MAX_PEERS = 8,
    parameter int AGE_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic [plm_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [plm_pkg::PEER_W-1:0]     i_peer,
    output logic                                o_valid,
    output logic      [plm_pkg::PEER_W-1:0]     o_peer_out,
    output logic      [plm_pkg::ACT_W-1:0]      o_action,
    output logic                                o_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [plm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [plm_pkg::CFG_W-1:0]      i_cfg_data
);

    import plm_pkg::*;

    localparam int WALK = (MAX_PEERS < MASK_W) ? MAX_PEERS : MASK_W;
    localparam int AW   = (WALK > 1) ? $clog2(WALK) : 1;
    localparam int CW   = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;
    localparam int EW   = 3 + 3 * AGE_BITS;

    t_state               r_state, n_state;
    t_kind                r_kind;
    logic                 r_walk;
    logic [PEER_W-1:0]    r_idx;
    logic [MASK_W-1:0]    r_mask;
    logic [CFG_W-1:0]     r_rec, r_hs, r_kp, r_kt;
    logic [WALK-1:0]      r_fresh;
    logic                 r_pend_vld;
    logic [PEER_W-1:0]    r_pend_peer;
    t_action              r_pend_act;
    t_action              r_sec_act;
    logic                 r_out_vld, r_out_last;
    logic [PEER_W-1:0]    r_out_peer;
    t_action              r_out_act;

    logic [AW-1:0]        addr;
    logic                 entry_on, last_idx;
    logic [EW-1:0]        rd_data, ent, wr_data;
    logic                 ram_we;

    t_link                e_st, c_st;
    logic                 e_up, c_up;
    logic [AGE_BITS-1:0]  e_sa, e_ka, e_si, b_sa, b_ka, b_si, c_sa, c_ka, c_si;
    logic                 a_v, b_v, first_v, sec_v;
    t_action              a_act, b_act, first_act;
    logic                 push_v;
    t_action              push_act;

    assign addr     = r_idx[AW-1:0];
    assign entry_on = ({1'b0, r_idx} < 4'(WALK)) && r_mask[r_idx];
    assign last_idx = (r_idx == PEER_W'(WALK - 1));
    assign ram_we   = (r_state == S_CALC);

    plm_ram #(.WIDTH(EW), .DEPTH(WALK)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (wr_data),
        .i_raddr (addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        ent  = r_fresh[addr] ? '0 : rd_data;
        e_st = t_link'(ent[EW-1 -: 2]);
        e_up = ent[3*AGE_BITS];
        e_sa = ent[3*AGE_BITS-1 -: AGE_BITS];
        e_ka = ent[2*AGE_BITS-1 -: AGE_BITS];
        e_si = ent[AGE_BITS-1:0];
        b_sa = (e_sa == '1) ? e_sa : AGE_BITS'(e_sa + 1'b1);
        b_ka = (e_ka == '1) ? e_ka : AGE_BITS'(e_ka + 1'b1);
        b_si = (e_si == '1) ? e_si : AGE_BITS'(e_si + 1'b1);
        c_st = e_st;
        c_up = e_up;
        c_sa = e_sa;
        c_ka = e_ka;
        c_si = e_si;
        a_v   = 1'b0;
        a_act = ACT_CONNECT;
        b_v   = 1'b0;
        b_act = ACT_REMOVE;
        case (r_kind)
            KIND_TICK: begin
                c_sa = b_sa;
                c_ka = b_ka;
                c_si = b_si;
                case (e_st)
                    LS_DISC: begin
                        if (CW'(b_sa) > CW'(r_rec)) begin
                            a_v  = 1'b1;
                            c_st = LS_CONN;
                            c_sa = '0;
                        end
                    end
                    LS_CONN, LS_LOGIN: begin
                        if (CW'(b_sa) > CW'(r_hs)) begin
                            c_st = LS_DISC;
                            c_sa = '0;
                        end
                    end
                    default: begin
                        if (CW'(b_ka) > CW'(r_kp)) begin
                            a_v   = 1'b1;
                            a_act = ACT_KEEPALIVE;
                            c_ka  = '0;
                        end
                        if (CW'(b_si) > CW'(r_kt)) begin
                            b_v  = 1'b1;
                            c_up = 1'b0;
                            c_st = LS_DISC;
                            c_sa = '0;
                        end
                    end
                endcase
            end
            KIND_RECONNECT: begin
                if (e_up || e_st != LS_DISC) begin
                    a_v   = 1'b1;
                    a_act = ACT_DISCONNECT;
                    b_v   = e_up;
                end
                c_up = 1'b0;
                c_st = LS_DISC;
                c_sa = '0;
            end
            KIND_CONN_ECHO: begin
                if (e_st == LS_CONN) begin
                    a_v   = 1'b1;
                    a_act = ACT_LOGIN;
                    c_st  = LS_LOGIN;
                    c_sa  = '0;
                end
            end
            KIND_LOGIN_ACK: begin
                if (e_st == LS_LOGIN) begin
                    a_v   = 1'b1;
                    a_act = ACT_ADD;
                    c_st  = LS_UP;
                    c_up  = 1'b1;
                    c_ka  = '0;
                    c_si  = '0;
                end
            end
            KIND_LOGIN_NACK: begin
                c_st = LS_DISC;
                c_sa = '0;
            end
            KIND_KEEPALIVE: begin
                if (e_up) begin
                    a_v   = 1'b1;
                    a_act = ACT_ALIVE;
                    c_si  = '0;
                end
            end
            KIND_DISCONNECT: begin
                b_v  = e_up;
                c_up = 1'b0;
                c_st = LS_DISC;
                c_sa = '0;
            end
            default: ;
        endcase
        first_v   = a_v || b_v;
        first_act = a_v ? a_act : b_act;
        sec_v     = a_v && b_v;
        wr_data   = {c_st, c_up, c_sa, c_ka, c_si};
    end

    always_comb begin
        push_v   = 1'b0;
        push_act = first_act;
        case (r_state)
            S_CALC: push_v = first_v;
            S_SEC: begin
                push_v   = 1'b1;
                push_act = r_sec_act;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (entry_on) begin
                    n_state = S_CALC;
                end else if (r_walk && !last_idx) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CALC: begin
                if (sec_v) begin
                    n_state = S_SEC;
                end else if (r_walk && !last_idx) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SEC: begin
                n_state = (r_walk && !last_idx) ? S_RD : S_DONE;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mask     <= '0;
            r_rec      <= RST_RECONNECT;
            r_hs       <= RST_HS_TIMEOUT;
            r_kp       <= RST_KA_PERIOD;
            r_kt       <= RST_KA_TIMEOUT;
            r_fresh    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= 1'b0;
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_ENABLE_MASK: begin
                        r_mask  <= i_cfg_data[MASK_W-1:0];
                        r_fresh <= r_fresh | (i_cfg_data[WALK-1:0] & ~r_mask[WALK-1:0]);
                    end
                    REG_RECONNECT:  r_rec <= i_cfg_data;
                    REG_HS_TIMEOUT: r_hs  <= i_cfg_data;
                    REG_KA_PERIOD:  r_kp  <= i_cfg_data;
                    REG_KA_TIMEOUT: r_kt  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_fresh[addr] <= 1'b0;
            end
            if (push_v) begin
                if (r_pend_vld) begin
                    r_out_vld  <= 1'b1;
                    r_out_last <= 1'b0;
                    r_out_peer <= r_pend_peer;
                    r_out_act  <= r_pend_act;
                end
                r_pend_vld  <= 1'b1;
                r_pend_peer <= r_idx;
                r_pend_act  <= push_act;
            end else if (r_state == S_DONE && r_pend_vld) begin
                r_out_vld  <= 1'b1;
                r_out_last <= 1'b1;
                r_out_peer <= r_pend_peer;
                r_out_act  <= r_pend_act;
                r_pend_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_kind <= t_kind'(i_kind);
            r_walk <= (i_kind == KIND_TICK) || (i_kind == KIND_RECONNECT);
            r_idx  <= ((i_kind == KIND_TICK) || (i_kind == KIND_RECONNECT)) ? '0 : i_peer;
        end else if ((r_state == S_RD && !entry_on && r_walk && !last_idx)
                  || (r_state == S_CALC && !sec_v && r_walk && !last_idx)
                  || (r_state == S_SEC && r_walk && !last_idx)) begin
            r_idx <= PEER_W'(r_idx + 1'b1);
        end
        if (r_state == S_CALC) begin
            r_sec_act <= b_act;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_out_vld;
    assign o_peer_out  = r_out_peer;
    assign o_action    = r_out_act;
    assign o_last      = r_out_last;
    assign o_cfg_ready = 1'b1;

`include "peer_link_manager_assert.svh"

    `PLM_CHECK(a_state_onehot, 1'b1, $onehot(r_state), "fsm state not one-hot")
    `PLM_CHECK(a_idle_flushed, !o_busy, !r_pend_vld, "pending result left while idle")
    `PLM_CHECK_NEXT(a_start_reads, i_start && !o_busy, r_state == S_RD, "accepted beat did not start")
    `PLM_CHECK(a_sec_after_calc, r_state == S_SEC, $past(r_state) == S_CALC, "second result out of order")

endmodule
`default_nettype wire
